### hdl/ptnp_pkg.sv
// package: widths, limits, transfer structs and status codes for the prime test block
package ptnp_pkg;

  localparam int unsigned ARG_BITS  = 20;
  localparam int unsigned ARG_LIMIT = 1000000;
  // trial divisors never exceed sqrt of the limit plus one wheel step
  localparam int unsigned DIV_W     = 11;
  localparam int unsigned SQ_W      = 22;
  localparam int unsigned CNT_W     = $clog2(ARG_BITS);

  localparam logic [ARG_BITS-1:0] LIMIT_V = ARG_BITS'(ARG_LIMIT);

  localparam logic MODE_TEST = 1'b0;
  localparam logic MODE_NEXT = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_LOW   = 2'd2;

  typedef struct packed {
    logic                mode;
    logic [ARG_BITS-1:0] value;
  } ptnp_in_t;

  typedef struct packed {
    logic                prime_flag;
    logic [ARG_BITS-1:0] prime_value;
    logic [1:0]          status;
  } ptnp_out_t;

endpackage

### hdl/prime_test_and_next_prime_top.sv
// top level: trial division prime test and next-prime search on one shared remainder unit
//
// usage
// - command channel: drive in_i and raise start_i; the transfer happens at the rising
//   edge where start_i is high and busy_o is low. busy_o stays high until the result
//   has been shown.
// - result channel: result_valid_o is high for exactly one cycle with result_o; the
//   receiver cannot stall, so it must take the transfer in that cycle.
// - mode 0 tests in_i.value; mode 1 searches value+1, value+2, ... for the first prime.
// - every candidate n is checked against divisors 2, 3, 5, 7, 11, 13, ... (6k-1, 6k+1)
//   while d*d <= n. each divisor costs one bit-serial restoring remainder pass over
//   all ARG_BITS candidate bits in ST_DIV, framed by the ST_CHECK and ST_EVAL states.
// - path from command transfer to result transfer: range and zero-start cases go
//   straight to ST_DONE, a test of 0 or 1 passes through ST_INIT first; a mode 0 test
//   of a prime n runs the divisor loop until d*d > n; composites stop at their
//   smallest factor. mode 1 adds that cost for every candidate up to the next
//   prime.
// - one item is in flight at a time; the next may start the cycle after the strobe.
// - reset (rst_ni low, asynchronous) returns the sequencer to idle and drops busy_o
//   and result_valid_o; no result is produced for an item that was cut off.
module prime_test_and_next_prime_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  ptnp_pkg::ptnp_in_t in_i,
  output logic               busy_o,
  output logic               result_valid_o,
  output ptnp_pkg::ptnp_out_t result_o
);
  import ptnp_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_INIT  = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_EVAL  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // item and candidate
  logic                mode_q, mode_d;
  logic [ARG_BITS-1:0] cand_q, cand_d;
  // divisor, its square and the wheel phase
  logic [DIV_W-1:0]    div_q, div_d;
  logic [SQ_W-1:0]     sq_q, sq_d;
  logic                wide_q, wide_d;
  // remainder unit
  logic [DIV_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  // result
  ptnp_out_t           res_q, res_d;

  logic [DIV_W:0]      trial;
  logic [DIV_W:0]      trial_sub;
  logic [SQ_W-1:0]     sq_step;
  logic [DIV_W-1:0]    div_step;
  logic [ARG_BITS:0]   cand_inc;

  // one restoring step: shift in the next candidate bit, subtract if it fits
  assign trial     = {rem_q, cand_q[cnt_q]};
  assign trial_sub = trial - {1'b0, div_q};

  assign cand_inc  = {1'b0, cand_q} + (ARG_BITS + 1)'(1);

  // next divisor on the wheel and its square: (d+s)^2 = d^2 + 2sd + s^2
  always_comb begin
    if (div_q == DIV_W'(2)) begin
      div_step = div_q + DIV_W'(1);
      sq_step  = sq_q + SQ_W'({div_q, 1'b0}) + SQ_W'(1);
    end else if (div_q == DIV_W'(3) || !wide_q) begin
      div_step = div_q + DIV_W'(2);
      sq_step  = sq_q + SQ_W'({div_q, 2'b00}) + SQ_W'(4);
    end else begin
      div_step = div_q + DIV_W'(4);
      sq_step  = sq_q + SQ_W'({div_q, 3'b000}) + SQ_W'(16);
    end
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cand_d  = cand_q;
    div_d   = div_q;
    sq_d    = sq_q;
    wide_d  = wide_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          mode_d = in_i.mode;
          res_d  = '{prime_flag: 1'b0, prime_value: '0, status: STATUS_OK};
          if (in_i.mode == MODE_TEST) begin
            cand_d = in_i.value;
            if (in_i.value > LIMIT_V) begin
              res_d.status = STATUS_RANGE;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_INIT;
            end
          end else if (in_i.value == '0) begin
            res_d.status = STATUS_LOW;
            state_d      = ST_DONE;
          end else if (in_i.value >= LIMIT_V) begin
            res_d.status = STATUS_RANGE;
            state_d      = ST_DONE;
          end else begin
            cand_d  = in_i.value + ARG_BITS'(1);
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        div_d  = DIV_W'(2);
        sq_d   = SQ_W'(4);
        wide_d = 1'b0;
        // zero and one are not prime (only reachable in mode 0)
        if (cand_q < ARG_BITS'(2)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sq_q > SQ_W'(cand_q)) begin
          // no divisor up to sqrt: candidate is prime
          res_d.prime_flag = 1'b1;
          if (mode_q == MODE_NEXT) begin
            res_d.prime_value = cand_q;
          end
          state_d = ST_DONE;
        end else begin
          rem_d   = '0;
          cnt_d   = CNT_W'(ARG_BITS - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, div_q}) begin
          rem_d = trial_sub[DIV_W-1:0];
        end else begin
          rem_d = trial[DIV_W-1:0];
        end
        if (cnt_q == '0) begin
          state_d = ST_EVAL;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_EVAL: begin
        if (rem_q == '0) begin
          if (mode_q == MODE_TEST) begin
            state_d = ST_DONE;
          end else if (cand_inc > {1'b0, LIMIT_V}) begin
            res_d.status = STATUS_RANGE;
            state_d      = ST_DONE;
          end else begin
            cand_d  = cand_inc[ARG_BITS-1:0];
            state_d = ST_INIT;
          end
        end else begin
          div_d = div_step;
          sq_d  = sq_step;
          if (div_q != DIV_W'(2) && div_q != DIV_W'(3)) begin
            wide_d = !wide_q;
          end
          state_d = ST_CHECK;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers need no reset
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    cand_q <= cand_d;
    div_q  <= div_d;
    sq_q   <= sq_d;
    wide_q <= wide_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_DONE);
  assign result_o       = res_q;

endmodule
